// ===== design/csp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_pkg
// Shared types, constants and the op letter decoder for the CIGAR packer.
// ----------------------------------------------------------------------------
package csp_pkg;

	localparam int RUN_W   = 28;
	localparam int TOTAL_W = 32;
	localparam int COUNT_W = 16;
	localparam int DIFF_W  = 33;
	localparam int KIND_W  = 2;
	localparam int DATA_W  = 120;  // 114 field bits padded to 15 bytes

	localparam logic [RUN_W-1:0]   RUN_MAX   = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_OP  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SUM = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERR = 2'd2;

	// error codes
	localparam logic ERR_ZERO_LEN = 1'b0;
	localparam logic ERR_BAD_OP   = 1'b1;

	// which total an op length feeds
	typedef enum logic [1:0] {
		SIDE_NONE = 2'd0,
		SIDE_READ = 2'd1,
		SIDE_REF  = 2'd2
	} side_t;

	typedef struct packed {
		logic       known;
		logic [3:0] code;
		side_t      side;
	} op_dec_t;

	localparam logic [7:0] CH_0  = "0";
	localparam logic [7:0] CH_9  = "9";
	localparam logic [7:0] CH_LA = "a";
	localparam logic [7:0] CH_LZ = "z";
	localparam logic [7:0] CASE_OFS = 8'd32;

	function automatic op_dec_t decode_op(input logic [7:0] ch);
		logic [7:0] up;
		op_dec_t    d;
		up = ch;
		if (ch >= CH_LA && ch <= CH_LZ) begin
			up = ch - CASE_OFS;
		end
		d = '{known: 1'b1, code: 4'd0, side: SIDE_NONE};
		unique case (up)
			"M": d.code = 4'd0;
			"I": begin d.code = 4'd1; d.side = SIDE_READ; end
			"D": begin d.code = 4'd2; d.side = SIDE_REF;  end
			"N": begin d.code = 4'd3; d.side = SIDE_REF;  end
			"S": begin d.code = 4'd4; d.side = SIDE_READ; end
			"H": begin d.code = 4'd5; d.side = SIDE_REF;  end
			"P": begin d.code = 4'd6; d.side = SIDE_REF;  end
			"=": d.code = 4'd7;
			"X": d.code = 4'd8;
			"B": begin d.code = 4'd9; d.side = SIDE_READ; end
			default: d.known = 1'b0;
		endcase
		return d;
	endfunction

endpackage

// ===== design/cigar_string_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_string_packer
// Packs CIGAR text, one character per word, into length<<4|code op words.
// ----------------------------------------------------------------------------
// Input stream: s_tdata[7:0] is one text character; s_tlast marks the
// terminator word (its character is ignored). Output stream: m_tuser is the
// result kind (op word, end summary, error), m_tdata carries the fields.
// Digits build the run length; an op letter emits an op word and updates the
// read/reference totals; the terminator emits the summary (ref - read, max),
// or an error if a length is pending, and clears per-string state. After an
// error, characters up to and including the terminator give no output.
// A result passes through the input register, then the result register.
// Throughput: one character per cycle while no result word waits on a
// stalled output, set by the combinational multiply-by-ten and total update.
// Words that give no result pass through even while the output is stalled;
// a word that gives a result waits in the input register until the result
// register is free, and s_tready drops only then.
// Reset (arst_n low) clears both registers and all string state.
// ----------------------------------------------------------------------------
module cigar_string_packer (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] char_code
	input  logic                       s_tlast,   // is_terminator
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [31:0] packed_op, [47:32] op_index, [80:48] length_difference,
	// [112:81] larger_total, [113] error_code, [119:114] zero
	output logic [csp_pkg::DATA_W-1:0] m_tdata,
	output logic [csp_pkg::KIND_W-1:0] m_tuser    // [1:0] result_kind
);
	import csp_pkg::*;

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	// string state
	logic [RUN_W-1:0]   run_q;
	logic               digit_q;
	logic [TOTAL_W-1:0] read_tot_q;
	logic [TOTAL_W-1:0] ref_tot_q;
	logic [COUNT_W-1:0] op_cnt_q;
	logic               err_q;

	// result register
	logic                 out_valid_q;
	logic [KIND_W-1:0]    kind_q;
	logic [TOTAL_W-1:0]   packed_q;
	logic [COUNT_W-1:0]   index_q;
	logic [DIFF_W-1:0]    diff_q;
	logic [TOTAL_W-1:0]   larger_q;
	logic                 ecode_q;

	// next values
	logic               has_res;
	logic [KIND_W-1:0]  kind_d;
	logic [TOTAL_W-1:0] packed_d;
	logic [DIFF_W-1:0]  diff_d;
	logic [TOTAL_W-1:0] larger_d;
	logic               ecode_d;
	logic [RUN_W-1:0]   run_d;
	logic               digit_d;
	logic [TOTAL_W-1:0] read_tot_d;
	logic [TOTAL_W-1:0] ref_tot_d;
	logic [COUNT_W-1:0] op_cnt_d;
	logic               err_d;

	logic               is_digit;
	logic [TOTAL_W-1:0] run_x10;
	logic [RUN_W-1:0]   run_sat;
	logic [TOTAL_W:0]   read_sum;
	logic [TOTAL_W:0]   ref_sum;
	op_dec_t            dec;
	logic               out_free;
	logic               adv;

	assign is_digit = (char_s1 >= CH_0) && (char_s1 <= CH_9);
	// acc*10 + digit fits in 32 bits for a 28-bit acc
	assign run_x10  = {1'b0, run_q, 3'b000} + {3'b000, run_q, 1'b0}
		+ {24'd0, char_s1 - CH_0};
	assign run_sat  = (run_x10 > {4'd0, RUN_MAX}) ? RUN_MAX : run_x10[RUN_W-1:0];
	assign read_sum = {1'b0, read_tot_q} + {5'd0, run_q};
	assign ref_sum  = {1'b0, ref_tot_q} + {5'd0, run_q};
	assign dec      = decode_op(char_s1);

	always_comb begin
		has_res    = 1'b0;
		kind_d     = KIND_OP;
		packed_d   = '0;
		diff_d     = '0;
		larger_d   = '0;
		ecode_d    = ERR_ZERO_LEN;
		run_d      = run_q;
		digit_d    = digit_q;
		read_tot_d = read_tot_q;
		ref_tot_d  = ref_tot_q;
		op_cnt_d   = op_cnt_q;
		err_d      = err_q;
		priority if (last_s1) begin
			if (!err_q) begin
				has_res = 1'b1;
				if (digit_q) begin
					kind_d  = KIND_ERR;
					ecode_d = ERR_BAD_OP;
				end else begin
					kind_d   = KIND_SUM;
					diff_d   = {1'b0, ref_tot_q} - {1'b0, read_tot_q};
					larger_d = (ref_tot_q > read_tot_q) ? ref_tot_q : read_tot_q;
				end
			end
			run_d      = '0;
			digit_d    = 1'b0;
			read_tot_d = '0;
			ref_tot_d  = '0;
			op_cnt_d   = '0;
			err_d      = 1'b0;
		end else if (err_q) begin
			has_res = 1'b0;
		end else if (is_digit) begin
			run_d   = run_sat;
			digit_d = 1'b1;
		end else if (!digit_q || run_q == '0) begin
			has_res = 1'b1;
			kind_d  = KIND_ERR;
			ecode_d = ERR_ZERO_LEN;
			err_d   = 1'b1;
		end else if (!dec.known) begin
			has_res = 1'b1;
			kind_d  = KIND_ERR;
			ecode_d = ERR_BAD_OP;
			err_d   = 1'b1;
		end else begin
			has_res  = 1'b1;
			kind_d   = KIND_OP;
			packed_d = {run_q, dec.code};
			if (dec.side == SIDE_READ) begin
				read_tot_d = read_sum[TOTAL_W] ? TOTAL_MAX : read_sum[TOTAL_W-1:0];
			end
			if (dec.side == SIDE_REF) begin
				ref_tot_d = ref_sum[TOTAL_W] ? TOTAL_MAX : ref_sum[TOTAL_W-1:0];
			end
			if (op_cnt_q != COUNT_MAX) begin
				op_cnt_d = op_cnt_q + 1'b1;
			end
			run_d   = '0;
			digit_d = 1'b0;
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign adv      = valid_s1 && (out_free || !has_res);
	assign s_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			run_q       <= '0;
			digit_q     <= 1'b0;
			read_tot_q  <= '0;
			ref_tot_q   <= '0;
			op_cnt_q    <= '0;
			err_q       <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv && has_res) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (adv) begin
				run_q      <= run_d;
				digit_q    <= digit_d;
				read_tot_q <= read_tot_d;
				ref_tot_q  <= ref_tot_d;
				op_cnt_q   <= op_cnt_d;
				err_q      <= err_d;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
		if (adv && has_res) begin
			kind_q   <= kind_d;
			packed_q <= packed_d;
			index_q  <= op_cnt_q;
			diff_q   <= diff_d;
			larger_q <= larger_d;
			ecode_q  <= ecode_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = kind_q;
	assign m_tdata  = {6'd0, ecode_q, larger_q, diff_q, index_q, packed_q};

endmodule

// ===== design/csp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csp_checker
// Port-level checks for the CIGAR packer, bound to the top level.
// ----------------------------------------------------------------------------
module csp_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       m_tvalid,
	input logic                       m_tready,
	input logic [csp_pkg::DATA_W-1:0] m_tdata,
	input logic [csp_pkg::KIND_W-1:0] m_tuser
);
	import csp_pkg::*;

	// stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// op word: nonzero run length and a code in range, summary fields zero
	a_op: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_OP |->
			m_tdata[31:4] != '0 && m_tdata[3:0] <= 4'd9 && m_tdata[113:48] == '0)
		else $error("malformed op word");

	// summary: no op word and no error code
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_SUM |-> m_tdata[31:0] == '0 && !m_tdata[113])
		else $error("malformed summary word");

	// error: only index and code may be set
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_ERR |-> m_tdata[31:0] == '0 && m_tdata[112:48] == '0)
		else $error("malformed error word");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[119:114] == '0)
		else $error("pad bits set");

endmodule

bind cigar_string_packer csp_checker u_csp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== dv/cigar_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_result_checker
// Watches both streams of the CIGAR packer, predicts every result word from
// the accepted characters and compares it field by field with the output.
// ----------------------------------------------------------------------------
module cigar_result_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	input  logic                       s_tready,
	input  logic [7:0]                 s_tdata,   // [7:0] char_code
	input  logic                       s_tlast,   // is_terminator
	input  logic                       m_tvalid,
	input  logic                       m_tready,
	// [31:0] packed_op, [47:32] op_index, [80:48] length_difference,
	// [112:81] larger_total, [113] error_code, [119:114] zero
	input  logic [csp_pkg::DATA_W-1:0] m_tdata,
	input  logic [csp_pkg::KIND_W-1:0] m_tuser,   // [1:0] result_kind
	output int                         mismatches,
	output int                         pending
);

	import csp_pkg::*;

	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_N  = 4'd3;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_H  = 4'd5;
	localparam logic [3:0] OP_P  = 4'd6;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;
	localparam logic [3:0] OP_B  = 4'd9;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [31:0]        packed_op;
		logic [COUNT_W-1:0] op_index;
		logic [DIFF_W-1:0]  len_diff;
		logic [TOTAL_W-1:0] larger;
		logic               err_code;
	} cigar_result_t;

	cigar_result_t expected_words[$];

	// per-string state of the predictor
	logic [RUN_W-1:0]   run_len;
	bit                 digits_pending;
	logic [TOTAL_W-1:0] read_total;
	logic [TOTAL_W-1:0] ref_total;
	logic [COUNT_W-1:0] op_count;
	bit                 err_hold;

	bit            emits;
	cigar_result_t pred;
	cigar_result_t want;

	function automatic logic [TOTAL_W-1:0] sat_total(input logic [TOTAL_W-1:0] a,
			input logic [TOTAL_W-1:0] b);
		logic [TOTAL_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
	endfunction

	task automatic clear_string();
		run_len        = '0;
		digits_pending = 1'b0;
		read_total     = '0;
		ref_total      = '0;
		op_count       = '0;
		err_hold       = 1'b0;
	endtask

	task automatic pack_char(input logic [7:0] ch, input logic term, output bit has_word,
			output cigar_result_t r);
		logic [7:0]        up;
		logic [3:0]        code;
		side_t             side;
		bit                known;
		logic [RUN_W+7:0]  acc;
		r        = '0;
		has_word = 1'b0;
		if (term) begin
			if (!err_hold) begin
				has_word   = 1'b1;
				r.op_index = op_count;
				if (digits_pending) begin
					// string ended in the middle of a length
					r.kind     = KIND_ERR;
					r.err_code = ERR_BAD_OP;
				end else begin
					r.kind     = KIND_SUM;
					r.len_diff = {1'b0, ref_total} - {1'b0, read_total};
					r.larger   = (ref_total > read_total) ? ref_total : read_total;
				end
			end
			clear_string();
		end else if (!err_hold) begin
			if (ch >= CH_0 && ch <= CH_9) begin
				acc = (RUN_W+8)'(run_len) * (RUN_W+8)'(10) + (RUN_W+8)'(ch - CH_0);
				run_len = (acc > (RUN_W+8)'(RUN_MAX)) ? RUN_MAX : acc[RUN_W-1:0];
				digits_pending = 1'b1;
			end else begin
				has_word   = 1'b1;
				r.op_index = op_count;
				up    = (ch >= CH_LA && ch <= CH_LZ) ? ch - CASE_OFS : ch;
				known = 1'b1;
				side  = SIDE_NONE;
				code  = OP_M;
				case (up)
					"M": code = OP_M;
					"I": begin code = OP_I; side = SIDE_READ; end
					"D": begin code = OP_D; side = SIDE_REF; end
					"N": begin code = OP_N; side = SIDE_REF; end
					"S": begin code = OP_S; side = SIDE_READ; end
					"H": begin code = OP_H; side = SIDE_REF; end
					"P": begin code = OP_P; side = SIDE_REF; end
					"=": code = OP_EQ;
					"X": code = OP_X;
					"B": begin code = OP_B; side = SIDE_READ; end
					default: known = 1'b0;
				endcase
				if (!digits_pending || run_len == '0) begin
					r.kind     = KIND_ERR;
					r.err_code = ERR_ZERO_LEN;
					err_hold   = 1'b1;
				end else if (!known) begin
					r.kind     = KIND_ERR;
					r.err_code = ERR_BAD_OP;
					err_hold   = 1'b1;
				end else begin
					r.kind      = KIND_OP;
					r.packed_op = {run_len, code};
					if (side == SIDE_READ) begin
						read_total = sat_total(read_total, TOTAL_W'(run_len));
					end else if (side == SIDE_REF) begin
						ref_total = sat_total(ref_total, TOTAL_W'(run_len));
					end
					if (op_count != COUNT_MAX) begin
						op_count = op_count + 1'b1;
					end
					run_len        = '0;
					digits_pending = 1'b0;
				end
			end
		end
	endtask

	task automatic cmp_field(input string field, input logic [63:0] exp_v,
			input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatches++;
			if (mismatches <= 10) begin
				$display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, exp_v,
					act_v);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_string();
			expected_words.delete();
			mismatches = 0;
			pending    = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("%0t: result word with nothing expected: kind %0h data %0h",
							$realtime, m_tuser, m_tdata);
					end
				end else begin
					want = expected_words.pop_front();
					cmp_field("result_kind", 64'(want.kind), 64'(m_tuser));
					cmp_field("packed_op", 64'(want.packed_op), 64'(m_tdata[31:0]));
					cmp_field("op_index", 64'(want.op_index), 64'(m_tdata[47:32]));
					cmp_field("length_difference", 64'(want.len_diff), 64'(m_tdata[80:48]));
					cmp_field("larger_total", 64'(want.larger), 64'(m_tdata[112:81]));
					cmp_field("error_code", 64'(want.err_code), 64'(m_tdata[113]));
					cmp_field("tdata padding", 64'd0, 64'(m_tdata[DATA_W-1:114]));
				end
			end
			if (s_tvalid && s_tready) begin
				pack_char(s_tdata, s_tlast, emits, pred);
				if (emits) begin
					expected_words.push_back(pred);
				end
			end
			pending = expected_words.size();
		end
	end

endmodule

// ===== dv/cigar_string_packer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_string_packer_tb
// Drives CIGAR text into the packer: a few directed strings, then random
// strings (mostly well formed, some broken, some noise) under varying stall
// patterns on both sides.
// ----------------------------------------------------------------------------
module cigar_string_packer_tb;

	import csp_pkg::*;

	localparam int STALL_CYCLES = 300;
	localparam int WD_LIMIT     = 2000;
	localparam int TAIL_CYCLES  = 8;

	logic                clk;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata  = '0;
	logic                s_tlast  = 1'b0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [DATA_W-1:0]   m_tdata;
	logic [KIND_W-1:0]   m_tuser;

	int    mismatches;
	int    pending;
	int    src_idle  = 0;
	int    sink_idle = 0;
	bit    stall_req = 1'b0;
	int    n_chars   = 0;
	int    idle_cnt  = 0;
	string op_letters = "MIDNSHP=XB";

	cigar_string_packer u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	cigar_result_checker u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// sink side: random backpressure, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (stall_req) begin
				m_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_req = 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle);
			end
		end
	end

	// no word moved on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
		if (idle_cnt >= WD_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic [7:0] ch, input bit term);
		while ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= term;
		@(posedge clk iff (s_tvalid && s_tready));
		n_chars++;
	endtask

	task automatic send_str(input string s);
		for (int i = 0; i < s.len(); i++) begin
			send_word(s[i], 1'b0);
		end
	endtask

	task automatic end_string();
		send_word(8'h00, 1'b1);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic bit is_op_char(input logic [7:0] c);
		logic [7:0] up;
		up = (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
		for (int i = 0; i < op_letters.len(); i++) begin
			if (op_letters[i] == up) return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic logic [7:0] rand_letter();
		logic [7:0] c;
		c = op_letters[$urandom_range(op_letters.len() - 1)];
		if (c != "=" && $urandom_range(1) == 1) c = c + CASE_OFS;
		return c;
	endfunction

	function automatic logic [7:0] rand_bad_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(255));
		end while ((c >= CH_0 && c <= CH_9) || is_op_char(c));
		return c;
	endfunction

	// mostly short lengths; some long enough to hit run length saturation
	function automatic string rand_len();
		string s;
		int    r;
		r = $urandom_range(99);
		if (r < 65) begin
			s = $sformatf("%0d", $urandom_range(99, 1));
		end else if (r < 90) begin
			s = $sformatf("%0d", $urandom_range(999999, 100));
		end else begin
			s = $sformatf("%0d", $urandom_range(9, 1));
			repeat ($urandom_range(11, 8)) s = {s, $sformatf("%0d", $urandom_range(9))};
		end
		if ($urandom_range(9) == 0) s = {"0", s};
		return s;
	endfunction

	task automatic send_cigar();
		int         n_ops;
		int         mode;
		int         bad_at;
		int         bad_kind;
		logic [7:0] c;
		string      side_set;
		mode = $urandom_range(99);
		if (mode < 8) begin
			// noise: anything goes, usually errors out on the first word
			send_word(8'($urandom_range(255)), 1'b0);
			repeat ($urandom_range(10)) send_word(8'($urandom_range(255)), 1'b0);
		end else if (mode < 11) begin
			// max lengths on one side drive that total into saturation
			side_set = ($urandom_range(1) == 1) ? string'("ISBisb") : string'("DNHPdnhp");
			repeat (17) begin
				send_str("268435455");
				send_word(side_set[$urandom_range(side_set.len() - 1)], 1'b0);
			end
		end else begin
			n_ops  = $urandom_range(6, 1);
			bad_at = (mode < 26) ? $urandom_range(n_ops - 1) : -1;
			for (int i = 0; i < n_ops; i++) begin
				if (i == bad_at) begin
					bad_kind = $urandom_range(3);
					case (bad_kind)
						0: send_str($urandom_range(1) ? string'("0") : string'("000"));
						1: ;
						default: send_str(rand_len());
					endcase
					if (bad_kind == 3) break;  // string ends with a length pending
					send_word((bad_kind == 2) ? rand_bad_char() : rand_letter(), 1'b0);
					repeat ($urandom_range(3)) send_word(8'($urandom_range(255)), 1'b0);
					break;
				end
				send_str(rand_len());
				send_word(rand_letter(), 1'b0);
			end
		end
		end_string();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed strings
		end_string();                      // empty string
		send_str("0M");
		end_string();                      // explicit zero length
		send_word(8'h00, 1'b0);            // op with no length
		send_word(8'hFF, 1'b0);            // ignored after the error
		end_string();
		send_str("5Q");
		end_string();                      // unknown op letter
		send_str("3");
		end_string();                      // length pending at the end
		send_str("2B7p");
		end_string();
		send_str("1");
		send_word(8'hFF, 1'b0);
		end_string();
		drain();

		src_idle  = 20;
		sink_idle = 88;
		while (n_chars < 500) send_cigar();
		drain();

		src_idle  = 88;
		sink_idle = 20;
		while (n_chars < 1000) send_cigar();
		drain();

		src_idle  = 0;
		sink_idle = 0;
		stall_req = 1'b1;
		repeat (4) send_cigar();
		drain();
		while (n_chars < 1450) send_cigar();
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
